// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Check that a consequent holds in the cycle after an antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Check that a consequent holds in the same cycle as an antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/azt_pkg.sv -----
`timescale 1ns / 1ps

package azt_pkg;

	// Breakpoint registers in the register map
	localparam int NUM_POINT_REGS = 4;

	// Control kinds carried on the input side
	localparam logic [1:0] KIND_AXIS   = 2'd0;
	localparam logic [1:0] KIND_BUTTON = 2'd1;
	localparam logic [1:0] KIND_HAT    = 2'd2;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_DEVICE   = 3'd0;
	localparam logic [2:0] REG_AXIS     = 3'd1;
	localparam logic [2:0] REG_POINTS   = 3'd2;
	localparam logic [2:0] REG_POINT_0  = 3'd3;
	localparam logic [2:0] REG_POINT_1  = 3'd4;
	localparam logic [2:0] REG_POINT_2  = 3'd5;
	localparam logic [2:0] REG_POINT_3  = 3'd6;
	localparam logic [2:0] REG_DISABLED = 3'd7;

	// Configuration seen by the evaluation logic
	typedef struct packed {
		logic [3:0]                           watched_device;
		logic [3:0]                           watched_axis;
		logic [2:0]                           points_in_use;
		logic [NUM_POINT_REGS-1:0][15:0]      point;
		logic                                 disabled;
	} cfg_t;

	// One control-change event
	typedef struct packed {
		logic [3:0]         device_id;
		logic [1:0]         control_kind;
		logic [3:0]         control_number;
		logic signed [15:0] axis_value;
	} evt_t;

	// One result item
	typedef struct packed {
		logic [2:0] zone_after;
		logic [2:0] action_zone;
		logic       action_taken;
		logic       triggered;
	} res_t;

endpackage

// ----- rtl/azt_regs.sv -----
`timescale 1ns / 1ps

module azt_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output azt_pkg::cfg_t     cfg
);
	import azt_pkg::*;

	logic [3:0]  watched_device_q;
	logic [3:0]  watched_axis_q;
	logic [2:0]  points_in_use_q;
	logic [NUM_POINT_REGS-1:0][15:0] point_q;
	logic        disabled_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	// Update the addressed register on a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_device_q <= 4'd0;
			watched_axis_q   <= 4'd0;
			points_in_use_q  <= 3'd1;
			point_q          <= '0;
			disabled_q       <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEVICE:   watched_device_q <= pwdata[3:0];
				REG_AXIS:     watched_axis_q   <= pwdata[3:0];
				REG_POINTS:   points_in_use_q  <= pwdata[2:0];
				REG_POINT_0:  point_q[0]       <= pwdata[15:0];
				REG_POINT_1:  point_q[1]       <= pwdata[15:0];
				REG_POINT_2:  point_q[2]       <= pwdata[15:0];
				REG_POINT_3:  point_q[3]       <= pwdata[15:0];
				REG_DISABLED: disabled_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, sign-extending breakpoints
	always_comb begin
		case (reg_idx)
			REG_DEVICE:   prdata = {28'd0, watched_device_q};
			REG_AXIS:     prdata = {28'd0, watched_axis_q};
			REG_POINTS:   prdata = {29'd0, points_in_use_q};
			REG_POINT_0:  prdata = {{16{point_q[0][15]}}, point_q[0]};
			REG_POINT_1:  prdata = {{16{point_q[1][15]}}, point_q[1]};
			REG_POINT_2:  prdata = {{16{point_q[2][15]}}, point_q[2]};
			REG_POINT_3:  prdata = {{16{point_q[3][15]}}, point_q[3]};
			REG_DISABLED: prdata = {31'd0, disabled_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg.watched_device = watched_device_q;
	assign cfg.watched_axis   = watched_axis_q;
	assign cfg.points_in_use  = points_in_use_q;
	assign cfg.point          = point_q;
	assign cfg.disabled       = disabled_q;

endmodule

// ----- rtl/azt_eval.sv -----
`timescale 1ns / 1ps

module azt_eval #(
	parameter int MAX_POINTS = 4
) (
	input  azt_pkg::cfg_t cfg,
	input  logic [2:0]    zone,
	input  azt_pkg::evt_t evt,
	output azt_pkg::res_t res
);
	import azt_pkg::*;

	localparam logic [2:0] MAX_N = 3'(MAX_POINTS);

	logic [2:0]         n;
	logic [2:0]         z;
	logic               match;
	logic               first;
	logic               last;
	logic               other;
	logic               step_up;
	logic               step_down;
	logic               trig;
	logic               act;
	logic [2:0]         nz;
	logic [2:0]         exact_zone;
	logic [2:0]         cnt;
	logic signed [15:0] v;

	// Breakpoint at a zone index; only the low bits select a register
	function automatic logic signed [15:0] pt(input logic [2:0] idx);
		return $signed(cfg.point[idx[1:0]]);
	endfunction

	assign v = evt.axis_value;

	// Clamp the breakpoint count and the stored zone
	always_comb begin
		if (cfg.points_in_use == 3'd0) begin
			n = 3'd1;
		end else if (cfg.points_in_use > MAX_N) begin
			n = MAX_N;
		end else begin
			n = cfg.points_in_use;
		end
		z = (zone > n) ? n : zone;
	end

	// Detect a step across the bounds of the stored zone
	always_comb begin
		match = (evt.device_id == cfg.watched_device) &&
		        (evt.control_kind == KIND_AXIS) &&
		        (evt.control_number == cfg.watched_axis);
		first = (z == 3'd0);
		last  = (z == n);
		other = !first && !last;
		step_up   = match && ((first && (v >= pt(3'd0))) || (other && (v >= pt(z))));
		step_down = match && !step_up &&
		            ((last && (v < pt(n - 3'd1))) || (other && (v < pt(z - 3'd1))));
		trig = step_up || step_down;
		act  = trig && !cfg.disabled;
		if (step_up) begin
			nz = z + 3'd1;
		end else if (step_down) begin
			nz = z - 3'd1;
		end else begin
			nz = 3'd0;
		end
	end

	// Recompute the zone exactly from the value
	always_comb begin
		cnt = 3'd0;
		for (int i = 0; i < NUM_POINT_REGS; i++) begin
			if ((3'(i) < n) && ($signed(cfg.point[i]) <= v)) begin
				cnt = cnt + 3'd1;
			end
		end
		if (v <= pt(3'd0)) begin
			exact_zone = 3'd0;
		end else if (v >= pt(n - 3'd1)) begin
			exact_zone = n;
		end else begin
			exact_zone = cnt;
		end
	end

	assign res.triggered    = trig;
	assign res.action_taken = act;
	assign res.action_zone  = nz;
	assign res.zone_after   = act ? exact_zone : zone;

endmodule

// ----- rtl/axis_zone_tracker.sv -----
`timescale 1ns / 1ps
// Axis zone tracker.
// Input stream s_axis: one control-change event per transfer. s_axis_tdata
// carries device id, control number and the Q15 axis value; s_axis_tuser
// carries the control kind. Every event gives exactly one result on m_axis:
// trigger flag, action flag, the zone whose action fires and the stored zone.
// The APB port sets the watched device and axis, up to four ascending
// breakpoints, the count in use and a disable bit; write it only while idle.
// The event waits in the input register, then the breakpoint compares and
// the zone register update load the output register, which drives m_axis.
// Throughput is one event per cycle while m_axis_tready is high; the zone
// register is read and written in the same cycle, so each event sees the
// zone left by the one before it.
// A stalled receiver holds the output register; one more event still enters
// the input register, after which s_axis_tready drops until m_axis_tready.
// Reset empties both registers, sets the stored zone to 0 and loads the
// register defaults (one breakpoint in use, all breakpoints 0).

module axis_zone_tracker #(
	parameter int MAX_POINTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Event stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] device_id, [7:4] control_number, [23:8] axis_value
	input  logic [23:0] s_axis_tdata,
	// [1:0] control_kind
	input  logic [1:0]  s_axis_tuser,
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] triggered, [1] action_taken, [4:2] action_zone, [7:5] zone_after
	output logic [7:0]  m_axis_tdata
);
	import azt_pkg::*;

	`include "assert_macros.svh"

	cfg_t       cfg;
	evt_t       evt_s1;
	logic       valid_s1;
	res_t       res;
	res_t       res_s2;
	logic       valid_s2;
	logic [2:0] zone_q;
	logic       in_xfer;
	logic       adv_s1;

	azt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	azt_eval #(
		.MAX_POINTS (MAX_POINTS)
	) u_eval (
		.cfg  (cfg),
		.zone (zone_q),
		.evt  (evt_s1),
		.res  (res)
	);

	// Advance the input register when the output register is free or drains
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Track occupancy of both stages and update the stored zone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			zone_q   <= 3'd0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				zone_q   <= res.zone_after;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the event fields on an input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			evt_s1.device_id      <= s_axis_tdata[3:0];
			evt_s1.control_number <= s_axis_tdata[7:4];
			evt_s1.axis_value     <= s_axis_tdata[23:8];
			evt_s1.control_kind   <= s_axis_tuser;
		end
	end

	// Load the result when the event leaves the input register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.zone_after, res_s2.action_zone,
	                        res_s2.action_taken, res_s2.triggered};

	// The stored zone never passes the largest breakpoint count
	`ASSERT_ALWAYS(a_zone_range, clk, arst_n, zone_q <= 3'(MAX_POINTS))
	// The stored zone moves only when an event is evaluated
	`ASSERT_NEXT(a_zone_hold, clk, arst_n, !adv_s1, $stable(zone_q))
	// A waiting result reports the zone currently stored
	`ASSERT_IMPL(a_zone_match, clk, arst_n, valid_s2, res_s2.zone_after == zone_q)
	// An action fires only for a triggering event
	`ASSERT_IMPL(a_act_trig, clk, arst_n, valid_s2 && res_s2.action_taken,
		res_s2.triggered)
	// A silent event reports zone 0 as its action zone
	`ASSERT_IMPL(a_quiet_zone, clk, arst_n, valid_s2 && !res_s2.triggered,
		res_s2.action_zone == 3'd0)

endmodule
